// ----- src/literal_pattern_verifier_assert.svh -----
// literal_pattern_verifier_assert.svh: assertion macros for the verifier checker
// depends on nothing; included by the checker file
`ifndef LITERAL_PATTERN_VERIFIER_ASSERT_SVH
`define LITERAL_PATTERN_VERIFIER_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define LPV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpv check failed: same-cycle implication");

// next-cycle implication, quiet while reset is high
`define LPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpv check failed: next-cycle implication");

`endif

// ----- src/lpv_pkg.sv -----
// lpv_pkg: types, constants and helpers shared by the literal pattern verifier
// depends on nothing
package lpv_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int ADDR_W      = $clog2(PATTERN_MAX);
  localparam int POS_W       = 8;
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [POS_W-1:0] POS_SAT = '1;

  // alive flag bit positions
  localparam int F_ASCII   = 0;
  localparam int F_ASCII_I = 1;
  localparam int F_WIDE    = 2;
  localparam int F_WIDE_I  = 3;
  localparam int F_XOR_W   = 4;
  localparam int F_XOR_A   = 5;
  localparam int N_FLAGS   = 6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_NONE        = 3'd0,
    MODE_ASCII       = 3'd1,
    MODE_ASCII_NOCASE = 3'd2,
    MODE_WIDE        = 3'd3,
    MODE_WIDE_NOCASE = 3'd4,
    MODE_XOR_WIDE    = 3'd5,
    MODE_XOR_ASCII   = 3'd6
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_ASCII_ENABLE   = 3'd1,
    REG_WIDE_ENABLE    = 3'd2,
    REG_NOCASE_ENABLE  = 3'd3,
    REG_XOR_ENABLE     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] load_index;
    logic [7:0] byte_value;
    logic       window_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] matched_len;
    logic       wide_match;
    logic [2:0] mode_hit;
    logic [7:0] xor_key;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic             ascii_enable;
    logic             wide_enable;
    logic             nocase_enable;
    logic             xor_enable;
  } cfg_t;

  // prefetched pattern bytes for the coming window byte
  typedef struct packed {
    logic [7:0] pat_a;
    logic [7:0] pat_w;
    logic [7:0] pat_first;
  } pat_rd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ----- src/lpv_cfg_regs.sv -----
// lpv_cfg_regs: configuration register bank of the verifier
// depends on lpv_pkg
module lpv_cfg_regs import lpv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= LEN_W'(1);
      cfg.ascii_enable   <= 1'b1;
      cfg.wide_enable    <= 1'b0;
      cfg.nocase_enable  <= 1'b0;
      cfg.xor_enable     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LEN_W-1:0];
        REG_ASCII_ENABLE:   cfg.ascii_enable   <= cfg_data[0];
        REG_WIDE_ENABLE:    cfg.wide_enable    <= cfg_data[0];
        REG_NOCASE_ENABLE:  cfg.nocase_enable  <= cfg_data[0];
        REG_XOR_ENABLE:     cfg.xor_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/lpv_pattern_store.sv -----
// lpv_pattern_store: pattern byte memory with two registered read ports
// depends on lpv_pkg
module lpv_pattern_store import lpv_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_w,
  output pat_rd_t           pat
);

  logic [7:0] mem [PATTERN_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read registers forward a write to the same address
  always_ff @(posedge clk) begin
    pat.pat_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    pat.pat_w <= (we && waddr == raddr_w) ? wdata : mem[raddr_w];
    if (we && waddr == '0) begin
      pat.pat_first <= wdata;
    end
  end

endmodule

// ----- src/lpv_window_track.sv -----
// lpv_window_track: per-byte mode tracking and result selection
// depends on lpv_pkg
module lpv_window_track import lpv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             accept,
  input  in_item_t         item,
  input  pat_rd_t          pat,
  output logic [POS_W-1:0] pos_next,
  output logic             push,
  output out_item_t        push_data
);

  logic [POS_W-1:0]   pos;
  logic [N_FLAGS-1:0] alive;
  logic [7:0]         key;

  logic               is_data;
  logic               active;
  logic [LEN_W-1:0]   len;
  logic [POS_W-1:0]   len2;
  logic [7:0]         d;
  logic [7:0]         key_eff;
  logic [N_FLAGS-1:0] alive_upd;
  logic [N_FLAGS-1:0] alive_cur;
  logic [POS_W:0]     n;
  logic               ok_a;
  logic               ok_w;
  mode_t              mode;

  assign is_data = accept && item.opcode == OP_DATA;
  assign active  = pos != POS_SAT;
  assign d       = item.byte_value;
  assign len     = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : cfg.pattern_length;
  assign len2    = {len, 1'b0};
  assign key_eff = (pos == '0) ? (d ^ pat.pat_first) : key;

  always_comb begin
    alive_upd = alive;
    if (pos < POS_W'(len)) begin
      if (d != pat.pat_a) alive_upd[F_ASCII] = 1'b0;
      if (fold_case(d) != fold_case(pat.pat_a)) alive_upd[F_ASCII_I] = 1'b0;
      if (d != (pat.pat_a ^ key_eff)) alive_upd[F_XOR_A] = 1'b0;
    end
    if (pos < len2) begin
      if (!pos[0]) begin
        if (d != pat.pat_w) alive_upd[F_WIDE] = 1'b0;
        if (fold_case(d) != fold_case(pat.pat_w)) alive_upd[F_WIDE_I] = 1'b0;
        if (d != (pat.pat_w ^ key_eff)) alive_upd[F_XOR_W] = 1'b0;
      end else begin
        if (d != 8'h00) begin
          alive_upd[F_WIDE]   = 1'b0;
          alive_upd[F_WIDE_I] = 1'b0;
        end
        if (d != key_eff) alive_upd[F_XOR_W] = 1'b0;
      end
    end
  end

  assign alive_cur = active ? alive_upd : alive;
  assign n         = {1'b0, pos} + (POS_W+1)'(1);
  assign ok_a      = len != '0 && n >= (POS_W+1)'(len);
  assign ok_w      = len != '0 && n >= (POS_W+1)'(len2);

  always_comb begin
    mode = MODE_NONE;
    if (cfg.nocase_enable) begin
      priority if (cfg.ascii_enable && ok_a && alive_cur[F_ASCII_I]) begin
        mode = MODE_ASCII_NOCASE;
      end else if (cfg.wide_enable && ok_w && alive_cur[F_WIDE_I]) begin
        mode = MODE_WIDE_NOCASE;
      end else begin
        mode = MODE_NONE;
      end
    end else begin
      priority if (cfg.ascii_enable && ok_a && alive_cur[F_ASCII]) begin
        mode = MODE_ASCII;
      end else if (cfg.wide_enable && ok_w && alive_cur[F_WIDE]) begin
        mode = MODE_WIDE;
      end else if (cfg.xor_enable && cfg.wide_enable && ok_w && alive_cur[F_XOR_W]) begin
        mode = MODE_XOR_WIDE;
      end else if (cfg.xor_enable && ok_a && alive_cur[F_XOR_A]) begin
        mode = MODE_XOR_ASCII;
      end else begin
        mode = MODE_NONE;
      end
    end
  end

  always_comb begin
    push_data.mode_hit   = mode;
    push_data.wide_match = (mode == MODE_WIDE || mode == MODE_WIDE_NOCASE ||
                            mode == MODE_XOR_WIDE);
    push_data.xor_key    = active ? key_eff : key;
    if (push_data.wide_match) begin
      push_data.matched_len = len2;
    end else if (mode != MODE_NONE) begin
      push_data.matched_len = 8'(len);
    end else begin
      push_data.matched_len = 8'h00;
    end
  end

  assign push = is_data && item.window_last;

  // address for the pattern prefetch of the next window byte
  always_comb begin
    if (rst) begin
      pos_next = '0;
    end else if (is_data && item.window_last) begin
      pos_next = '0;
    end else if (is_data && active) begin
      pos_next = pos + POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      alive <= '1;
      key   <= 8'h00;
    end else if (is_data) begin
      pos <= pos_next;
      if (active) begin
        key <= key_eff;
      end
      if (item.window_last) begin
        alive <= '1;
      end else if (active) begin
        alive <= alive_upd;
      end
    end
  end

endmodule

// ----- src/lpv_out_buf.sv -----
// lpv_out_buf: result register with one skid entry
// depends on lpv_pkg
module lpv_out_buf import lpv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  logic      skid_valid;
  out_item_t skid;
  logic      pop;

  assign pop  = result_valid && result_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid) begin
      result_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || (pop && !skid_valid)) begin
      if (push) result <= push_data;
    end else if (pop) begin
      result <= skid;
      if (push) skid <= push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

// ----- src/literal_pattern_verifier.sv -----
// literal_pattern_verifier: top level of the literal pattern verifier
// depends on lpv_pkg, lpv_cfg_regs, lpv_pattern_store, lpv_window_track, lpv_out_buf
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------
//  item     | in        | item_valid / item_ready    | in_item_t (load or window byte)
//  result   | out       | result_valid / result_ready| out_item_t (one per last byte)
//  cfg      | in        | cfg_we, no wait            | cfg_index, cfg_data
//
// one item is taken per cycle while the skid entry is free; a window byte marked last
// puts its result in the result register, or in the skid entry under output stall
// pattern bytes are prefetched into registers from the next window position, two read
// ports on the pattern memory (single-byte and wide positions), so this sets the rate
// item_ready drops only while both the result register and its skid entry are full
// rst is synchronous: window position, mode flags, key and registers return to reset;
// the pattern memory is not cleared and needs no clearing pass
module literal_pattern_verifier import lpv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  pat_rd_t          pat;
  logic             accept;
  logic             store_we;
  logic [POS_W-1:0] pos_next;
  logic             push;
  out_item_t        push_data;
  logic             buf_full;

  // an item transfers whenever the skid entry is free
  assign item_ready = !buf_full;
  assign accept     = item_valid && item_ready;
  assign store_we   = accept && item.opcode == OP_LOAD;

  lpv_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // single-byte modes read entry pos, wide modes entry pos/2
  lpv_pattern_store u_pattern_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (item.load_index),
    .wdata   (item.byte_value),
    .raddr_a (pos_next[ADDR_W-1:0]),
    .raddr_w (pos_next[ADDR_W:1]),
    .pat     (pat)
  );

  // six mode flags narrowed byte by byte, result chosen on the last byte
  lpv_window_track u_window_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .item      (item),
    .pat       (pat),
    .pos_next  (pos_next),
    .push      (push),
    .push_data (push_data)
  );

  // result plus skid register; input flows under output stall until the skid fills
  lpv_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- src/lpv_checker.sv -----
// lpv_checker: port-level assertions for literal_pattern_verifier, bound to the top
// depends on lpv_pkg and literal_pattern_verifier_assert.svh
`include "literal_pattern_verifier_assert.svh"

module lpv_checker import lpv_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_ready,
  input in_item_t              item,
  input logic                  result_valid,
  input logic                  result_ready,
  input out_item_t             result
);

  logic wide_mode;

  assign wide_mode = result.mode_hit == MODE_WIDE || result.mode_hit == MODE_WIDE_NOCASE ||
                     result.mode_hit == MODE_XOR_WIDE;

  // a stalled item holds
  `LPV_ASSERT_NEXT(a_item_hold, clk, rst, item_valid && !item_ready,
    item_valid && $stable(item))

  // a stalled result holds
  `LPV_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready,
    result_valid && $stable(result))

  // no hit exactly when length is zero
  `LPV_ASSERT_IMP(a_len_vs_mode, clk, rst, result_valid,
    (result.mode_hit == MODE_NONE) == (result.matched_len == 8'h00))

  // wide flag follows the wide modes
  `LPV_ASSERT_IMP(a_wide_flag, clk, rst, result_valid, result.wide_match == wide_mode)

  // a wide match covers an even byte count
  `LPV_ASSERT_IMP(a_wide_even, clk, rst, result_valid && result.wide_match,
    !result.matched_len[0])

endmodule

bind literal_pattern_verifier lpv_checker u_lpv_checker (.*);
